@@ src/longest_remaining_time_scheduler_top_assert.svh @@
// assertion macros for the longest remaining time scheduler
// used by the top level, no other dependencies
`ifndef LONGEST_REMAINING_TIME_SCHEDULER_TOP_ASSERT_SVH
`define LONGEST_REMAINING_TIME_SCHEDULER_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define LRTS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define LRTS_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define LRTS_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define LRTS_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

@@ src/lrts_pkg.sv @@
// shared constants and types of the longest remaining time scheduler
// no dependencies
`default_nettype none
package lrts_pkg;
  localparam int MAX_PROCS = 16;
  localparam int ARR_W     = 12;
  localparam int BUR_W     = 8;
  localparam int ID_W      = 5;
  localparam int TIME_W    = 13;
  localparam int TOT_W     = 18;
  localparam int IDX_W     = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
  localparam int CNT_W     = $clog2(MAX_PROCS + 1);
  // wide enough for the latest possible completion
  localparam int CLK_W     = $clog2((1 << ARR_W) + MAX_PROCS * ((1 << BUR_W) - 1) + 1);

  // best candidate and earliest pending arrival, handed along the chain
  typedef struct packed {
    logic             found;
    logic [BUR_W-1:0] rem;
    logic [ARR_W-1:0] arr;
    logic [IDX_W-1:0] idx;
    logic             pend;
    logic [ARR_W-1:0] next_arr;
  } scan_t;

  // per cell command from the controller
  typedef struct packed {
    logic             load;
    logic             dec;
    logic [ARR_W-1:0] arr;
    logic [BUR_W-1:0] burst;
  } cell_cmd_t;
endpackage
`default_nettype wire

@@ src/lrts_cell.sv @@
// one process slot of the scheduler chain: holds arrival, burst, remaining, finish
// and compares itself against the candidate from its left neighbour; uses lrts_pkg
`default_nettype none
module lrts_cell (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic [lrts_pkg::IDX_W-1:0] cell_idx,
  input  logic                       live,
  input  logic [lrts_pkg::CLK_W-1:0] clock_now,
  input  lrts_pkg::cell_cmd_t        cmd,
  input  lrts_pkg::scan_t            scan_in,
  output lrts_pkg::scan_t            scan_out,
  output logic [lrts_pkg::ARR_W-1:0] arr_q,
  output logic [lrts_pkg::BUR_W-1:0] burst_q,
  output logic [lrts_pkg::CLK_W-1:0] finish_q
);
  import lrts_pkg::*;

  logic [ARR_W-1:0] arr_r;
  logic [BUR_W-1:0] burst_r;
  logic [BUR_W-1:0] rem_r;
  logic [CLK_W-1:0] finish_r;
  scan_t            scan_r;
  scan_t            scan_nxt;
  logic             eligible;
  logic             arrived;
  logic             better;

  assign eligible = live && (rem_r != '0);
  assign arrived  = ({{(CLK_W-ARR_W){1'b0}}, arr_r} <= clock_now);
  assign better   = !scan_in.found || (rem_r > scan_in.rem) ||
                    ((rem_r == scan_in.rem) && (arr_r < scan_in.arr));

  always_comb begin
    scan_nxt = scan_in;
    if (eligible && arrived && better) begin
      scan_nxt.found = 1'b1;
      scan_nxt.rem   = rem_r;
      scan_nxt.arr   = arr_r;
      scan_nxt.idx   = cell_idx;
    end
    if (eligible && !arrived && (!scan_in.pend || (arr_r < scan_in.next_arr))) begin
      scan_nxt.pend     = 1'b1;
      scan_nxt.next_arr = arr_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_r <= '0;
    end else begin
      scan_r <= scan_nxt;
    end
  end

  // slot contents, no reset
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      arr_r    <= cmd.arr;
      burst_r  <= cmd.burst;
      rem_r    <= cmd.burst;
      // a zero burst completes at its arrival
      finish_r <= {{(CLK_W-ARR_W){1'b0}}, cmd.arr};
    end else if (cmd.dec) begin
      rem_r <= rem_r - BUR_W'(1);
      if (rem_r == BUR_W'(1)) begin
        finish_r <= clock_now + CLK_W'(1);
      end
    end
  end

  assign scan_out = scan_r;
  assign arr_q    = arr_r;
  assign burst_q  = burst_r;
  assign finish_q = finish_r;
endmodule
`default_nettype wire

@@ src/longest_remaining_time_scheduler_top.sv @@
// loading: one item per cycle; a set closes on final_process or when MAX_PROCS are held
// run: each time unit of service, and each idle jump, waits while the candidate travels
//   down the chain of cells, and then the pick is applied
// results: one per cycle in load order when out_ready stays high
// reset: rst_n synchronous, active low, clears the controller and output valid
`default_nettype none
`include "longest_remaining_time_scheduler_top_assert.svh"
module longest_remaining_time_scheduler_top (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [lrts_pkg::ARR_W-1:0]  in_arrival_time,
  input  logic [lrts_pkg::BUR_W-1:0]  in_burst_time,
  input  logic                        in_final_process,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [lrts_pkg::ID_W-1:0]   out_process_id,
  output logic [lrts_pkg::TIME_W-1:0] out_completion_time,
  output logic [lrts_pkg::TIME_W-1:0] out_turnaround,
  output logic [lrts_pkg::TIME_W-1:0] out_waiting,
  output logic [lrts_pkg::TOT_W-1:0]  out_total_turnaround,
  output logic [lrts_pkg::TOT_W-1:0]  out_total_waiting,
  output logic                        out_last_result
);
  import lrts_pkg::*;

  // controller states
  localparam logic [1:0] ST_LOAD = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_EMIT = 2'd2;

  logic [1:0]       state_r;
  logic [CNT_W-1:0] load_cnt_r;   // slots filled in the set being loaded
  logic [CNT_W-1:0] n_r;          // size of the set being run or reported
  logic [CLK_W-1:0] clock_r;      // simulated time
  logic [CNT_W-1:0] scan_cnt_r;   // cycles since the cell contents last changed
  logic [IDX_W-1:0] emit_idx_r;
  logic [TOT_W-1:0] tot_tat_r;
  logic [TOT_W-1:0] tot_wt_r;

  logic              out_valid_r;
  logic [ID_W-1:0]   out_id_r;
  logic [TIME_W-1:0] out_ct_r;
  logic [TIME_W-1:0] out_tat_r;
  logic [TIME_W-1:0] out_wt_r;
  logic [TOT_W-1:0]  out_ttat_r;
  logic [TOT_W-1:0]  out_twt_r;
  logic              out_last_r;

  // chain wiring: scan[0] is an empty candidate, scan[MAX_PROCS] the tail
  scan_t            scan [MAX_PROCS+1];
  logic [ARR_W-1:0] arr_q [MAX_PROCS];
  logic [BUR_W-1:0] bur_q [MAX_PROCS];
  logic [CLK_W-1:0] fin_q [MAX_PROCS];
  scan_t            tail;

  logic             in_fire;
  logic             final_load;
  logic [IDX_W-1:0] load_idx;
  logic             decide;
  logic             emit_fire;
  logic             emit_last;

  logic [ARR_W-1:0] sel_arr;
  logic [BUR_W-1:0] sel_bur;
  logic [CLK_W-1:0] sel_fin;
  logic [CLK_W-1:0] tat;
  logic [CLK_W-1:0] wt;
  logic [TOT_W-1:0] tot_tat_nxt;
  logic [TOT_W-1:0] tot_wt_nxt;

  assign in_ready   = (state_r == ST_LOAD);
  assign in_fire    = in_valid && in_ready;
  assign load_idx   = load_cnt_r[IDX_W-1:0];
  // a full set runs even without the final mark
  assign final_load = in_final_process || (load_cnt_r == CNT_W'(MAX_PROCS - 1));

  // tail is settled once the candidate has passed every cell
  assign tail   = scan[MAX_PROCS];
  assign decide = (state_r == ST_SCAN) && (scan_cnt_r == CNT_W'(MAX_PROCS));

  assign emit_fire = (state_r == ST_EMIT) && (!out_valid_r || out_ready);
  assign emit_last = ((CNT_W'(emit_idx_r) + CNT_W'(1)) == n_r);

  assign scan[0] = '0;

  for (genvar k = 0; k < MAX_PROCS; k++) begin : g_cell
    cell_cmd_t cmd;
    logic      live;

    assign live      = (CNT_W'(k) < n_r);
    assign cmd.load  = in_fire && (load_idx == IDX_W'(k));
    assign cmd.dec   = decide && tail.found && (tail.idx == IDX_W'(k));
    assign cmd.arr   = in_arrival_time;
    assign cmd.burst = in_burst_time;

    lrts_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .cell_idx  (IDX_W'(k)),
      .live      (live),
      .clock_now (clock_r),
      .cmd       (cmd),
      .scan_in   (scan[k]),
      .scan_out  (scan[k+1]),
      .arr_q     (arr_q[k]),
      .burst_q   (bur_q[k]),
      .finish_q  (fin_q[k])
    );
  end

  // result of the slot being reported
  assign sel_arr     = arr_q[emit_idx_r];
  assign sel_bur     = bur_q[emit_idx_r];
  assign sel_fin     = fin_q[emit_idx_r];
  assign tat         = sel_fin - {{(CLK_W-ARR_W){1'b0}}, sel_arr};
  assign wt          = tat - {{(CLK_W-BUR_W){1'b0}}, sel_bur};
  assign tot_tat_nxt = tot_tat_r + TOT_W'(tat);
  assign tot_wt_nxt  = tot_wt_r + TOT_W'(wt);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_LOAD;
      load_cnt_r  <= '0;
      n_r         <= '0;
      clock_r     <= '0;
      scan_cnt_r  <= '0;
      emit_idx_r  <= '0;
      tot_tat_r   <= '0;
      tot_wt_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // a new item replaces the one leaving, otherwise the register empties
      if (emit_fire) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_LOAD: begin
          if (in_fire) begin
            if (final_load) begin
              n_r        <= load_cnt_r + CNT_W'(1);
              load_cnt_r <= '0;
              clock_r    <= '0;
              scan_cnt_r <= '0;
              state_r    <= ST_SCAN;
            end else begin
              load_cnt_r <= load_cnt_r + CNT_W'(1);
            end
          end
        end
        ST_SCAN: begin
          if (decide) begin
            scan_cnt_r <= '0;
            priority if (tail.found) begin
              clock_r <= clock_r + CLK_W'(1);
            end else if (tail.pend) begin
              // idle until the next arrival
              clock_r <= {{(CLK_W-ARR_W){1'b0}}, tail.next_arr};
            end else begin
              // nothing left to run
              emit_idx_r <= '0;
              tot_tat_r  <= '0;
              tot_wt_r   <= '0;
              state_r    <= ST_EMIT;
            end
          end else begin
            scan_cnt_r <= scan_cnt_r + CNT_W'(1);
          end
        end
        ST_EMIT: begin
          if (emit_fire) begin
            tot_tat_r   <= tot_tat_nxt;
            tot_wt_r    <= tot_wt_nxt;
            emit_idx_r  <= emit_idx_r + IDX_W'(1);
            if (emit_last) begin
              state_r <= ST_LOAD;
            end
          end
        end
        default: begin
          state_r <= ST_LOAD;
        end
      endcase
    end
  end

  // output payload, no reset
  always_ff @(posedge clk) begin
    if (emit_fire) begin
      out_id_r   <= ID_W'(emit_idx_r) + ID_W'(1);
      out_ct_r   <= sel_fin[TIME_W-1:0];
      out_tat_r  <= tat[TIME_W-1:0];
      out_wt_r   <= wt[TIME_W-1:0];
      out_ttat_r <= tot_tat_nxt;
      out_twt_r  <= tot_wt_nxt;
      out_last_r <= emit_last;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_process_id       = out_id_r;
  assign out_completion_time  = out_ct_r;
  assign out_turnaround       = out_tat_r;
  assign out_waiting          = out_wt_r;
  assign out_total_turnaround = out_ttat_r;
  assign out_total_waiting    = out_twt_r;
  assign out_last_result      = out_last_r;

  // a picked process always belongs to the live set
  `LRTS_ASSERT_IMP(a_pick_live, clk, rst_n, decide && tail.found,
    (CNT_W'(tail.idx) < n_r))
  // an idle jump always moves time forward
  `LRTS_ASSERT_IMP(a_jump_fwd, clk, rst_n, decide && !tail.found && tail.pend,
    ({{(CLK_W-ARR_W){1'b0}}, tail.next_arr} > clock_r))
  // the last report returns the controller to loading
  `LRTS_ASSERT_NXT(a_emit_end, clk, rst_n, emit_fire && emit_last,
    (state_r == ST_LOAD) && out_valid_r && out_last_r)
endmodule
`default_nettype wire
